FILE: rtl/int_to_decimal_ascii_macros.svh
// Assertion macros shared by the integer to decimal text converter.
`ifndef INT_TO_DECIMAL_ASCII_MACROS_SVH
`define INT_TO_DECIMAL_ASCII_MACROS_SVH

// Checks that a property holds at every clock edge outside reset.
`define ITDA_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

// Checks that a condition in one cycle implies another in the next cycle.
`define ITDA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

FILE: rtl/itda_pkg.sv
// Types, constants and tables shared by the integer to decimal text converter.
`default_nettype none

package itda_pkg;

    localparam int ValueWidth        = 32;
    localparam int CharWidth         = 6;
    localparam int DigitCountWidth   = 4;
    localparam int MaxDigits         = 10;
    localparam int MultWidth         = 34;
    localparam int QueueDepthDefault = 2;

    localparam logic [CharWidth-1:0] AsciiZero  = 6'd48;
    localparam logic [CharWidth-1:0] AsciiMinus = 6'd45;

    // Table of d * 10^k for every digit position k and digit d.
    typedef logic [MaxDigits-1:0][9:0][MultWidth-1:0] t_mult_table;

    // One classified number on its way from the front to the back.
    typedef struct packed {
        logic                       neg;
        logic [ValueWidth-1:0]      mag;
        logic [DigitCountWidth-1:0] ndig;
    } t_item;

    // Write side of the item queue.
    typedef struct packed {
        logic  push;
        t_item item;
    } t_q_wr;

    // Fill status of the item queue.
    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

    // States of the character emitter.
    typedef enum logic [1:0] {
        S_IDLE,
        S_SIGN,
        S_DIGIT
    } t_back_state;

    // Builds the multiple table at elaboration.
    function automatic t_mult_table f_mult_table();
        t_mult_table       v_t;
        longint unsigned   v_p;
        v_p = 1;
        for (int k = 0; k < MaxDigits; k++) begin
            for (int d = 0; d < 10; d++) begin
                v_t[k][d] = MultWidth'(v_p * longint'(d));
            end
            v_p = v_p * 10;
        end
        return v_t;
    endfunction

    localparam t_mult_table MultTable = f_mult_table();

endpackage

`default_nettype wire

FILE: rtl/int_to_decimal_ascii.sv
// Top level of the signed 32-bit integer to decimal ASCII text converter.
//
// Input channel: i_valid, i_value and o_stall; a number is taken at a clock
// edge with i_valid high and o_stall low. Output channel: o_valid,
// o_char_code and o_last_char with i_stall; one character is taken at an
// edge with o_valid high and i_stall low.
// Each number yields its decimal text, leading digit first, with a leading
// '-' for negative values; o_last_char marks the final character.
// A number passes from the front-end register through the queue to the
// character emitter, which fetches it from the queue in its idle state and
// then loads one character per cycle into the output register while the
// output is not stalled; this emitter sets the throughput.
// A small queue between the front end and the emitter lets the next numbers
// be taken while characters are still going out.
// A stall on the output holds the current character; the emitter waits and,
// once the queue fills, o_stall rises on the input.
// Reset (synchronous, active low) empties the queue and all pipeline stages.
`default_nettype none

module int_to_decimal_ascii #(
    parameter int QueueDepth = itda_pkg::QueueDepthDefault
) (
    input  wire                                          i_clk,
    input  wire                                          i_rst_n,
    input  wire                                          i_valid,
    input  wire logic signed [itda_pkg::ValueWidth-1:0]  i_value,
    output logic                                         o_stall,
    output logic                                         o_valid,
    output logic [itda_pkg::CharWidth-1:0]               o_char_code,
    output logic                                         o_last_char,
    input  wire                                          i_stall
);
    import itda_pkg::*;

    t_q_wr   q_wr;
    t_q_stat q_stat;
    t_item   q_item;
    logic    q_pop;

    itda_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .i_value  (i_value),
        .o_stall  (o_stall),
        .i_q_stat (q_stat),
        .o_q_wr   (q_wr)
    );

    itda_queue #(
        .Depth (QueueDepth)
    ) u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_q_wr   (q_wr),
        .i_pop    (q_pop),
        .o_q_stat (q_stat),
        .o_item   (q_item)
    );

    itda_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_stat    (q_stat),
        .i_item      (q_item),
        .o_pop       (q_pop),
        .i_stall     (i_stall),
        .o_valid     (o_valid),
        .o_char_code (o_char_code),
        .o_last_char (o_last_char)
    );

endmodule

`default_nettype wire

FILE: rtl/itda_front.sv
// Front end: takes numbers, forms sign and magnitude, counts decimal digits.
`default_nettype none

module itda_front (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    input  wire                                i_valid,
    input  wire logic signed [itda_pkg::ValueWidth-1:0] i_value,
    output logic                               o_stall,
    input  itda_pkg::t_q_stat                  i_q_stat,
    output itda_pkg::t_q_wr                    o_q_wr
);
    import itda_pkg::*;

    logic                       r_valid;
    logic                       n_valid;
    logic                       r_neg;
    logic [ValueWidth-1:0]      r_mag;
    logic                       accept;
    logic                       push;
    logic [ValueWidth-1:0]      in_mag;
    logic [DigitCountWidth-1:0] ndig;

    // The stage holds one number until the queue has room for it.
    assign push    = r_valid && !i_q_stat.full;
    assign o_stall = r_valid && i_q_stat.full;
    assign accept  = i_valid && !o_stall;

    // Two's complement magnitude; the most negative value maps to 2^31.
    assign in_mag = i_value[ValueWidth-1] ? (~$unsigned(i_value) + 32'd1)
                                          : $unsigned(i_value);

    always_comb begin
        n_valid = r_valid;
        if (accept) begin
            n_valid = 1'b1;
        end else if (push) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_neg <= i_value[ValueWidth-1];
            r_mag <= in_mag;
        end
    end

    // Digit count: one more than the exponent of the highest power of ten not above the magnitude.
    always_comb begin
        ndig = DigitCountWidth'(1);
        for (int k = 1; k < MaxDigits; k++) begin
            if ({2'b00, r_mag} >= MultTable[k][1]) begin
                ndig = DigitCountWidth'(k + 1);
            end
        end
    end

    assign o_q_wr.push      = push;
    assign o_q_wr.item.neg  = r_neg;
    assign o_q_wr.item.mag  = r_mag;
    assign o_q_wr.item.ndig = ndig;

endmodule

`default_nettype wire

FILE: rtl/itda_queue.sv
// Short first-in first-out queue of classified numbers between front and back.
`default_nettype none

`include "int_to_decimal_ascii_macros.svh"

module itda_queue #(
    parameter int Depth = itda_pkg::QueueDepthDefault
) (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  itda_pkg::t_q_wr    i_q_wr,
    input  wire                i_pop,
    output itda_pkg::t_q_stat  o_q_stat,
    output itda_pkg::t_item    o_item
);
    import itda_pkg::*;

    localparam int PtrW = $clog2(Depth);
    localparam int CntW = $clog2(Depth + 1);

    t_item            r_entry [Depth];
    logic [PtrW-1:0]  r_wr;
    logic [PtrW-1:0]  n_wr;
    logic [PtrW-1:0]  r_rd;
    logic [PtrW-1:0]  n_rd;
    logic [CntW-1:0]  r_count;
    logic [CntW-1:0]  n_count;
    logic             do_push;
    logic             do_pop;

    assign o_q_stat.full  = (r_count == CntW'(Depth));
    assign o_q_stat.empty = (r_count == '0);
    assign do_push        = i_q_wr.push && !o_q_stat.full;
    assign do_pop         = i_pop && !o_q_stat.empty;
    assign o_item         = r_entry[r_rd];

    // Pointer and fill count update.
    always_comb begin
        n_wr    = r_wr;
        n_rd    = r_rd;
        n_count = r_count;
        if (do_push) begin
            n_wr = (r_wr == PtrW'(Depth - 1)) ? '0 : r_wr + 1'b1;
        end
        if (do_pop) begin
            n_rd = (r_rd == PtrW'(Depth - 1)) ? '0 : r_rd + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (do_pop && !do_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_entry[r_wr] <= i_q_wr.item;
        end
    end

    `ITDA_ASSERT(a_count_bound, i_clk, i_rst_n, r_count <= CntW'(Depth), "queue count overflow")
    `ITDA_ASSERT(a_no_push_full, i_clk, i_rst_n, !(i_q_wr.push && o_q_stat.full), "push while full")

endmodule

`default_nettype wire

FILE: rtl/itda_back.sv
// Back end: emits sign, then one decimal digit per unstalled cycle, leading first.
`default_nettype none

`include "int_to_decimal_ascii_macros.svh"

module itda_back (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    input  itda_pkg::t_q_stat                   i_q_stat,
    input  itda_pkg::t_item                     i_item,
    output logic                                o_pop,
    input  wire                                 i_stall,
    output logic                                o_valid,
    output logic [itda_pkg::CharWidth-1:0]      o_char_code,
    output logic                                o_last_char
);
    import itda_pkg::*;

    t_back_state                r_state;
    t_back_state                n_state;
    logic [ValueWidth-1:0]      r_rem;
    logic [ValueWidth-1:0]      n_rem;
    logic [DigitCountWidth-1:0] r_pos;
    logic [DigitCountWidth-1:0] n_pos;
    logic                       r_valid;
    logic [CharWidth-1:0]       r_char;
    logic                       r_last;
    logic                       slot_free;
    logic                       load;
    logic [CharWidth-1:0]       load_char;
    logic                       load_last;
    logic [3:0]                 sel_digit;
    logic [ValueWidth-1:0]      sel_rest;

    // The output register is free when empty or being taken this cycle.
    assign slot_free = !r_valid || !i_stall;

    // Digit at the current position: the largest multiple of 10^pos that fits.
    always_comb begin
        logic [MultWidth:0] v_diff;
        sel_digit = '0;
        sel_rest  = r_rem;
        for (int d = 1; d < 10; d++) begin
            v_diff = {3'b000, r_rem} - {1'b0, MultTable[r_pos][4'(d)]};
            if (!v_diff[MultWidth]) begin
                sel_digit = 4'(d);
                sel_rest  = v_diff[ValueWidth-1:0];
            end
        end
    end

    // Sequencer: fetch a number, emit its sign, then its digits.
    always_comb begin
        n_state   = r_state;
        n_rem     = r_rem;
        n_pos     = r_pos;
        o_pop     = 1'b0;
        load      = 1'b0;
        load_char = AsciiZero;
        load_last = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (!i_q_stat.empty) begin
                    o_pop   = 1'b1;
                    n_rem   = i_item.mag;
                    n_pos   = i_item.ndig - 1'b1;
                    n_state = i_item.neg ? S_SIGN : S_DIGIT;
                end
            end
            S_SIGN: begin
                if (slot_free) begin
                    load      = 1'b1;
                    load_char = AsciiMinus;
                    n_state   = S_DIGIT;
                end
            end
            S_DIGIT: begin
                if (slot_free) begin
                    load      = 1'b1;
                    load_char = AsciiZero + {2'b00, sel_digit};
                    load_last = (r_pos == '0);
                    n_rem     = sel_rest;
                    if (r_pos == '0) begin
                        n_state = S_IDLE;
                    end else begin
                        n_pos = r_pos - 1'b1;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem <= n_rem;
        r_pos <= n_pos;
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (load) begin
            r_valid <= 1'b1;
        end else if (!i_stall) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_char <= load_char;
            r_last <= load_last;
        end
    end

    assign o_valid     = r_valid;
    assign o_char_code = r_char;
    assign o_last_char = r_last;

    `ITDA_ASSERT(a_last_digit_small, i_clk, i_rst_n, (r_state != S_DIGIT) || (r_pos != '0) || (r_rem < 32'd10), "last digit remainder too large")
    `ITDA_ASSERT(a_last_is_digit, i_clk, i_rst_n, !(o_valid && o_last_char && (o_char_code == AsciiMinus)), "sign flagged as last character")
    `ITDA_ASSERT_NEXT(a_sign_then_digit, i_clk, i_rst_n, (r_state == S_SIGN) && slot_free, r_state == S_DIGIT)

endmodule

`default_nettype wire

FILE: verif/int_to_decimal_ascii_tb.sv
// Self-checking testbench for the signed integer to decimal ASCII text converter.
`timescale 1ns / 100ps

module int_to_decimal_ascii_tb;

    import itda_pkg::*;

    localparam int ClkPeriod  = 12;
    localparam int RandCount  = 260;
    localparam int StallLimit = 2000;
    localparam int TailCycles = 20;
    localparam int DirCount   = 20;

    // One character of a number's decimal text.
    typedef struct packed {
        logic [CharWidth-1:0] code;
        logic                 last;
    } t_text_char;

    logic                         i_clk = 1'b0;
    logic                         i_rst_n;
    logic                         i_valid;
    logic signed [ValueWidth-1:0] i_value;
    logic                         o_stall;
    logic                         o_valid;
    logic [CharWidth-1:0]         o_char_code;
    logic                         o_last_char;
    logic                         i_stall = 1'b0;

    t_text_char pending_text [$];
    int         fail_count    = 0;
    int         send_gap_pct  = 0;
    int         recv_hold_pct = 0;
    int         quiet_cycles  = 0;

    // Directed numbers; a non-empty text is the known answer for that row.
    logic signed [ValueWidth-1:0] dir_value [DirCount] = '{
        32'sd0, 32'sh8000_0000, 32'sh7FFF_FFFF, -32'sd1, 32'sd1,
        -32'sd2147483647, 32'sd9, 32'sd10, 32'sd99, 32'sd100,
        -32'sd9, -32'sd10, 32'sd999999999, 32'sd1000000000, -32'sd1000000000,
        32'sd123456789, -32'sd987654321, 32'sh5555_5555, 32'shAAAA_AAAA, 32'sd7
    };
    string dir_text [DirCount] = '{
        "0", "-2147483648", "2147483647", "-1", "1",
        "", "", "", "", "",
        "", "", "", "", "",
        "", "", "", "", ""
    };

    int_to_decimal_ascii u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .i_value     (i_value),
        .o_stall     (o_stall),
        .o_valid     (o_valid),
        .o_char_code (o_char_code),
        .o_last_char (o_last_char),
        .i_stall     (i_stall)
    );

    always #(ClkPeriod / 2) i_clk = ~i_clk;

    // Queues the characters that a number should produce, leading digit first.
    function automatic void predict_text(input logic signed [ValueWidth-1:0] number);
        longint     mag;
        int         ndig;
        logic [3:0] digit [MaxDigits];
        mag = longint'(number);
        if (number < 0) begin
            mag = -mag;
        end
        ndig = 0;
        do begin
            digit[ndig] = 4'(mag % 10);
            mag         = mag / 10;
            ndig++;
        end while (mag != 0);
        if (number < 0) begin
            pending_text.push_back('{AsciiMinus, 1'b0});
        end
        for (int k = ndig - 1; k >= 0; k--) begin
            pending_text.push_back('{AsciiZero + CharWidth'(digit[k]), k == 0});
        end
    endfunction

    // Queues a known answer given as text.
    function automatic void queue_known_text(input string txt);
        for (int k = 0; k < txt.len(); k++) begin
            pending_text.push_back('{CharWidth'(txt[k]), k == txt.len() - 1});
        end
    endfunction

    // Picks a number: raw words, a chosen digit count, powers of ten and
    // their neighbors, small values, or the two ends of the range.
    function automatic logic signed [ValueWidth-1:0] pick_number();
        longint lo;
        longint hi;
        longint mag;
        int     n;
        case ($urandom_range(4))
            0: begin
                return $urandom;
            end
            1: begin
                n  = $urandom_range(1, 10);
                lo = 1;
                repeat (n - 1) lo = lo * 10;
                hi = lo * 10 - 1;
                if (n == 1) begin
                    lo = 0;
                end
                if (hi > 64'sd2147483647) begin
                    hi = 64'sd2147483647;
                end
                mag = lo + (longint'($urandom) % (hi - lo + 1));
            end
            2: begin
                mag = 1;
                repeat ($urandom_range(9)) mag = mag * 10;
                mag = mag + int'($urandom_range(2)) - 1;
            end
            3: begin
                mag = $urandom_range(20);
            end
            default: begin
                return $urandom_range(1) ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
            end
        endcase
        return $urandom_range(1) ? 32'(-mag) : 32'(mag);
    endfunction

    // Offers one number, with random idle cycles ahead of it, and records
    // its expected text when the block takes it. Starts and ends at a falling edge.
    task automatic send_number(input logic signed [ValueWidth-1:0] number,
                               input string known);
        while ($urandom_range(99) < send_gap_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_value <= number;
        do @(posedge i_clk); while (o_stall);
        if (known.len() != 0) begin
            queue_known_text(known);
        end else begin
            predict_text(number);
        end
        @(negedge i_clk);
    endtask

    // The receiver holds off characters at random.
    always @(negedge i_clk) begin
        i_stall <= ($urandom_range(99) < recv_hold_pct);
    end

    // Compares every accepted character with the oldest expected one.
    always @(posedge i_clk) begin : check_text
        t_text_char want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_text.size() == 0) begin
                $error("unexpected character: char_code %0d last_char %0d",
                       o_char_code, o_last_char);
                fail_count++;
            end else begin
                want = pending_text.pop_front();
                if (o_char_code !== want.code) begin
                    $error("char_code: expected %0d, got %0d", want.code, o_char_code);
                    fail_count++;
                end
                if (o_last_char !== want.last) begin
                    $error("last_char: expected %0d, got %0d", want.last, o_last_char);
                    fail_count++;
                end
            end
        end
    end

    // Ends a run in which neither channel moves for too long.
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= StallLimit) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // Reset, then the directed numbers, then three phases of random numbers.
    initial begin
        i_rst_n       = 1'b0;
        i_valid       = 1'b0;
        i_value       = '0;
        send_gap_pct  = 28;
        recv_hold_pct = 57;
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        for (int r = 0; r < DirCount; r++) begin
            send_number(dir_value[r], dir_text[r]);
        end

        for (int r = 0; r < RandCount; r++) begin
            if (r == RandCount / 3) begin
                send_gap_pct  = 57;
                recv_hold_pct = 28;
            end else if (r == 2 * RandCount / 3) begin
                send_gap_pct  = 0;
                recv_hold_pct = 0;
            end
            send_number(pick_number(), "");
        end
        i_valid <= 1'b0;

        // Drain the outstanding characters, then watch for strays.
        wait (pending_text.size() == 0);
        repeat (TailCycles) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
